### hw/rtl/trle_pkg.sv
// shared types and constants for the tga run-length pixel decoder
// no dependencies

package trle_pkg;

  localparam int DepthW = 3;
  localparam int CountW = 25;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegDepth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCount = 1'b1;

  localparam logic [DepthW-1:0] DepthReset = 3'd4;
  localparam logic [CountW-1:0] CountReset = 25'd65536;
  localparam logic [CountW-1:0] MaxPixels = 25'd16777216;

  localparam logic [7:0] RunBase = 8'd127;

  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_PIXEL  = 2'b10
  } trle_phase_t;

  typedef struct packed {
    logic [31:0] accum;
    logic [2:0]  depth;
    logic [7:0]  rep;
    logic        last;
    logic        ovr;
  } trle_item_t;

endpackage

### hw/rtl/trle_front.sv
// front end: chunk header parsing, pixel byte assembly and image pixel accounting
// depends on trle_pkg

module trle_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                in_byte,
  output logic                      in_ready,
  input  logic [trle_pkg::DepthW-1:0] depth,
  input  logic [trle_pkg::CountW-1:0] total,
  input  logic                      room,
  output logic                      item_valid,
  output trle_pkg::trle_item_t      item
);
  import trle_pkg::*;

  trle_phase_t       phase, phase_next;
  logic              in_run, in_run_next;
  logic [7:0]        chunk_left, chunk_left_next;
  logic [1:0]        byte_slot, byte_slot_next;
  logic [31:0]       pixel_accum, pixel_accum_next;
  logic [CountW-1:0] pixels_done, pixels_done_next;

  logic              accept;
  logic [2:0]        slot_inc;
  logic              px_done;
  logic [31:0]       accum_or;
  logic [CountW:0]   diff;
  logic [CountW-1:0] rem;
  logic              rem_one;
  logic [7:0]        cl_eff;
  logic [7:0]        cl_dec;
  logic              ov_run;
  logic [7:0]        rep;
  logic              last;
  logic              ovr;

  assign in_ready = room;
  assign accept   = in_valid & room;

  assign slot_inc = {1'b0, byte_slot} + 3'd1;
  assign px_done  = slot_inc >= depth;
  assign accum_or = pixel_accum | ({24'd0, in_byte} << {byte_slot, 3'b000});

  assign diff    = {1'b0, total} - {1'b0, pixels_done};
  assign rem     = (diff[CountW] || diff == '0) ? CountW'(1) : diff[CountW-1:0];
  assign rem_one = rem == CountW'(1);
  assign cl_eff  = (chunk_left == 8'd0) ? 8'd1 : chunk_left;
  assign cl_dec  = cl_eff - 8'd1;
  assign ov_run  = {17'd0, cl_eff} > rem;

  always_comb begin
    if (in_run) begin
      rep  = ov_run ? rem[7:0] : cl_eff;
      last = {17'd0, cl_eff} >= rem;
      ovr  = ov_run;
    end else begin
      rep  = 8'd1;
      last = rem_one;
      ovr  = rem_one && (cl_dec != 8'd0);
    end
  end

  assign item_valid = accept && (phase == PH_PIXEL) && px_done;
  assign item.accum = accum_or;
  assign item.depth = depth;
  assign item.rep   = rep;
  assign item.last  = last;
  assign item.ovr   = ovr;

  always_comb begin
    phase_next       = phase;
    in_run_next      = in_run;
    chunk_left_next  = chunk_left;
    byte_slot_next   = byte_slot;
    pixel_accum_next = pixel_accum;
    pixels_done_next = pixels_done;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          in_run_next      = in_byte[7];
          chunk_left_next  = in_byte[7] ? (in_byte - RunBase) : (in_byte + 8'd1);
          byte_slot_next   = 2'd0;
          pixel_accum_next = 32'd0;
          phase_next       = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (!px_done) begin
            pixel_accum_next = accum_or;
            byte_slot_next   = slot_inc[1:0];
          end else begin
            pixel_accum_next = 32'd0;
            byte_slot_next   = 2'd0;
            chunk_left_next  = in_run ? 8'd0 : cl_dec;
            if (last) begin
              pixels_done_next = '0;
              chunk_left_next  = 8'd0;
              phase_next       = PH_HEADER;
            end else begin
              pixels_done_next = pixels_done + {17'd0, rep};
              if (in_run || cl_dec == 8'd0) begin
                phase_next = PH_HEADER;
              end
            end
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      in_run      <= 1'b0;
      chunk_left  <= 8'd0;
      byte_slot   <= 2'd0;
      pixel_accum <= 32'd0;
      pixels_done <= '0;
    end else begin
      phase       <= phase_next;
      in_run      <= in_run_next;
      chunk_left  <= chunk_left_next;
      byte_slot   <= byte_slot_next;
      pixel_accum <= pixel_accum_next;
      pixels_done <= pixels_done_next;
    end
  end

endmodule

### hw/rtl/trle_queue.sv
// two-entry queue of finished pixels between front and back
// depends on trle_pkg

module trle_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  trle_pkg::trle_item_t push_item,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 room,
  output trle_pkg::trle_item_t head
);
  import trle_pkg::*;

  trle_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = count != 2'd0;
  assign room      = count != 2'd2;
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/trle_back.sv
// back end: depth masking and the output register of the result stream
// depends on trle_pkg

module trle_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  trle_pkg::trle_item_t q_item,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);
  import trle_pkg::*;

  logic [31:0] mask;

  always_comb begin
    case (q_item.depth)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {q_item.rep, q_item.accum & mask};
      m_tlast <= q_item.last;
      m_tuser <= q_item.ovr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### hw/rtl/tga_rle_pixel_decoder.sv
// tga run-length pixel decoder, one compressed byte per beat
// a pixel's result is written into the queue, then into the output register, after the beat with its last byte
// throughput: one input beat per cycle while the queue has room; one result per finished pixel
// the front end keeps taking bytes while up to two results wait for the output side
// reset: synchronous, clears parse state and queue, depth to 4 and pixel count to 65536
// depends on trle_pkg, trle_front, trle_queue, trle_back

module tga_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // pixel_value, repeat_count
  output logic                          m_tlast,   // last_of_image
  output logic                          m_tuser,   // overrun
  input  logic                          cfg_we,
  input  logic [trle_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [trle_pkg::CountW-1:0]   cfg_data
);
  import trle_pkg::*;

  logic [DepthW-1:0] depth_reg;
  logic [CountW-1:0] count_reg;
  logic [DepthW-1:0] depth;
  logic [CountW-1:0] total;

  logic       item_valid;
  trle_item_t item;
  logic       room;
  logic       q_valid;
  trle_item_t q_item;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_reg <= DepthReset;
      count_reg <= CountReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDepth: depth_reg <= cfg_data[DepthW-1:0];
        RegCount: count_reg <= cfg_data;
        default:  depth_reg <= depth_reg;
      endcase
    end
  end

  always_comb begin
    if (depth_reg == 3'd0) begin
      depth = 3'd1;
    end else if (depth_reg > 3'd4) begin
      depth = 3'd4;
    end else begin
      depth = depth_reg;
    end
    if (count_reg == '0) begin
      total = CountW'(1);
    end else if (count_reg > MaxPixels) begin
      total = MaxPixels;
    end else begin
      total = count_reg;
    end
  end

  trle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_ready   (s_tready),
    .depth      (depth),
    .total      (total),
    .room       (room),
    .item_valid (item_valid),
    .item       (item)
  );

  trle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid),
    .push_item (item),
    .pop       (pop),
    .not_empty (q_valid),
    .room      (room),
    .head      (q_item)
  );

  trle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### hw/rtl/trle_checker.sv
// port-level checks for the tga run-length pixel decoder, bound to the top level
// depends on tga_rle_pixel_decoder

module trle_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [7:0]                    s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [39:0]                   m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);

  a_in_holds: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input beat changed while stalled");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_rep_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:32] != 8'd0 && m_tdata[39:32] <= 8'd128)
    else $error("repeat count out of range");

  a_overrun_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("clipped chunk did not end the image");

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .m_tuser   (m_tuser)
);

### tb/tga_rle_pixel_decoder_tb.sv
// self-checking testbench for tga_rle_pixel_decoder: directed cases, then random images
// predicts every pixel beat from the compressed byte stream and compares each result beat
// depends on trle_pkg and tga_rle_pixel_decoder

module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trle_pkg::*;

  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  reps;
    logic        last;
    logic        ovr;
  } pixel_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // data_byte
  logic                m_tvalid;
  logic                m_tready;
  logic [39:0]         m_tdata;   // pixel_value, repeat_count
  logic                m_tlast;   // last_of_image
  logic                m_tuser;   // overrun
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CountW-1:0]   cfg_data;

  // decoder shadow state
  trle_phase_t         dec_phase = PH_HEADER;
  logic                dec_in_run = 1'b0;
  logic [7:0]          dec_left = 8'd0;
  logic [1:0]          dec_slot = 2'd0;
  logic [31:0]         dec_accum = 32'd0;
  logic [CountW-1:0]   dec_done = '0;
  logic [DepthW-1:0]   cfg_depth = DepthReset;
  logic [CountW-1:0]   cfg_count = CountReset;

  pixel_result_t       pending_pixels[$];
  int                  mismatches = 0;
  int                  beats_sent = 0;
  int                  pixels_checked = 0;
  int                  stall_left = 0;
  bit                  tx_gaps = 1'b1;
  bit                  rx_gaps = 1'b1;

  tga_rle_pixel_decoder uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[tga_rle_pixel_decoder] ERROR");
    $finish;
  end

  task automatic decode_byte(input logic [7:0] b);
    logic [DepthW-1:0] bpp;
    logic [CountW-1:0] total;
    logic [CountW-1:0] rem;
    logic [CountW-1:0] rep;
    logic [31:0]       value;
    logic              ovr;
    logic              last;
    bpp = (cfg_depth == 0) ? 3'd1 : (cfg_depth > 4) ? 3'd4 : cfg_depth;
    total = (cfg_count == 0) ? 25'd1 : (cfg_count > MaxPixels) ? MaxPixels : cfg_count;
    if (dec_phase == PH_HEADER) begin
      dec_in_run = b[7];
      dec_left = b[7] ? b - RunBase : b + 8'd1;
      dec_slot = 2'd0;
      dec_accum = 32'd0;
      dec_phase = PH_PIXEL;
      return;
    end
    dec_accum = dec_accum | ({24'd0, b} << (8 * dec_slot));
    if (dec_slot + 3'd1 < bpp) begin
      dec_slot = dec_slot + 2'd1;
      return;
    end
    dec_slot = 2'd0;
    case (bpp)
      3'd1: value = dec_accum & 32'h0000_00ff;
      3'd2: value = dec_accum & 32'h0000_ffff;
      3'd3: value = dec_accum & 32'h00ff_ffff;
      default: value = dec_accum;
    endcase
    dec_accum = 32'd0;
    rem = (total > dec_done) ? total - dec_done : 25'd1;
    if (dec_left == 0) dec_left = 8'd1;
    if (dec_in_run) begin
      rep = {17'd0, dec_left};
      ovr = rep > rem;
      if (ovr) rep = rem;
      dec_left = 8'd0;
    end else begin
      rep = 25'd1;
      dec_left = dec_left - 8'd1;
      ovr = (rem == 1) && (dec_left != 0);
    end
    dec_done = dec_done + rep;
    last = dec_done >= total;
    if (last) begin
      dec_done = '0;
      dec_left = 8'd0;
      dec_phase = PH_HEADER;
    end else if (dec_left == 0) begin
      dec_phase = PH_HEADER;
    end
    pending_pixels.push_back('{value, rep[7:0], last, ovr});
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      pixels_checked++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result beat, pixel", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[31:0] !== want.pixel)
          report_mismatch("pixel_value", m_tdata[31:0], want.pixel);
        if (m_tdata[39:32] !== want.reps)
          report_mismatch("repeat_count", 32'(m_tdata[39:32]), 32'(want.reps));
        if (m_tlast !== want.last)
          report_mismatch("last_of_image", 32'(m_tlast), 32'(want.last));
        if (m_tuser !== want.ovr)
          report_mismatch("overrun", 32'(m_tuser), 32'(want.ovr));
      end
    end
  end

  // output stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    decode_byte(b);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegDepth) cfg_depth = val[DepthW-1:0];
    else cfg_count = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_header();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
    return ($urandom_range(0, 1) == 1) ? 8'(len + 127) : 8'(len - 1);
  endfunction

  task automatic test_default_config();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7f);
  endtask

  task automatic test_depth_and_count_limits();
    // depth 0 acts as 1, run of 128 clipped at the image end
    write_reg(RegDepth, 25'd0);
    write_reg(RegCount, 25'd3);
    send_byte(8'hff);
    send_byte(8'ha5);
    // depth above 4, count 0, raw chunk of 128 cut after one pixel
    write_reg(RegDepth, 25'd7);
    write_reg(RegCount, 25'd0);
    send_byte(8'h7f);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h04);
    send_byte(8'h08);
  endtask

  task automatic test_depth_change_mid_pixel();
    write_reg(RegDepth, 25'd3);
    write_reg(RegCount, 25'h1ff_ffff);
    send_byte(8'h80);
    send_byte(8'h11);
    send_byte(8'h22);
    write_reg(RegDepth, 25'd2);
    send_byte(8'h33);
  endtask

  task automatic test_count_lowered_mid_image();
    write_reg(RegCount, MaxPixels);
    send_byte(8'h02);
    send_byte(8'hff);
    send_byte(8'hff);
    write_reg(RegCount, 25'd1);
    send_byte(8'h00);
    send_byte(8'h01);
  endtask

  task automatic test_random_images();
    logic [DepthW-1:0] depth;
    logic [CountW-1:0] count;
    logic [21:0]       junk;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: depth = 3'd1;
        1: depth = 3'd4;
        2: depth = 3'd2;
        3: depth = 3'd0;
        4: depth = 3'd3;
        5: depth = 3'd5;
        6: depth = 3'd6;
        default: depth = 3'd4;
      endcase
      case (ph)
        3: count = 25'h1ff_ffff;
        5: count = 25'd0;
        6: count = MaxPixels;
        default: count = 25'($urandom_range(1, 40));
      endcase
      junk = 22'($urandom);
      tx_gaps = (ph < 7);
      rx_gaps = (ph < 7);
      write_reg(RegDepth, {junk, depth});
      write_reg(RegCount, count);
      repeat (92) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
        else if (dec_phase == PH_HEADER) send_byte(pick_header());
        else send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    cfg_we <= 1'b0;
    cfg_index <= RegDepth;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_depth_and_count_limits();
    test_depth_change_mid_pixel();
    test_count_lowered_mid_image();
    test_random_images();
    drain();

    $display("sent %0d stream bytes, checked %0d pixel beats", beats_sent, pixels_checked);
    $display("depths 0..7, counts 0 to above max, clipped runs and raw chunks, config mid-image");
    if (mismatches == 0) begin
      $display("[tga_rle_pixel_decoder] OK");
    end else begin
      $display("[tga_rle_pixel_decoder] ERROR");
    end
    $finish;
  end

endmodule
